>>> sv/lseg_pkg.sv
package lseg_pkg;

   // field widths fixed by the payload format
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS_DEF = 24;
   localparam int WET_BITS = 17;
   localparam int WET_FRAC = 16;
   localparam int CSR_INDEX_BITS = 3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TREBLE_KEEP = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BASS_KEEP = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ATTACK_BASE = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WET_MIX = 3'd4;

   // reset values, given for 24 coefficient bits (rescaled in the top level)
   localparam longint TREBLE_KEEP_RST = 64'd16773219;
   localparam longint BASS_KEEP_RST = 64'd16775168;
   localparam longint ATTACK_BASE_RST = 64'd12583;
   localparam longint RST_COEF_BITS = 64'd24;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_left;
      logic signed [SAMPLE_BITS-1:0] sample_right;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_left;
      logic signed [SAMPLE_BITS-1:0] out_right;
   } rsp_type;

endpackage

>>> sv/linked_stereo_envelope_gate_top.sv
// Linked stereo envelope gate. One stereo transaction in (Q1.23 left/right) gives one
// stereo transaction out. The louder channel's magnitude opens the gate when it exceeds
// threshold_level; the corner levels then move, treble up an attack step, bass down
// twice that, lowpass states snap to the input and highpass states clear; otherwise
// both levels decay through the keep multipliers. Output is lowpass minus highpass
// from one of two alternating banks (zero unless treble is above bass), mixed with
// the dry input by wet_mix and saturated. All products run through one bit-serial
// shift-add multiplier, one multiplier bit per cycle: a frame runs nine products
// with the gate closed and seven with it open. A new request transaction is taken
// only when the previous frame has left the sequencer; the finished frame waits in
// the output register so the next request can be taken while it is stalled. Config
// registers may be written only while the block is idle.
module linked_stereo_envelope_gate_top #(
   parameter int COEF_BITS = lseg_pkg::COEF_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lseg_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lseg_pkg::rsp_type    rsp_data,
   input  logic                 csr_we,
   input  logic [lseg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [((lseg_pkg::SAMPLE_BITS > COEF_BITS + 1) ?
                  lseg_pkg::SAMPLE_BITS : COEF_BITS + 1) - 1:0] csr_data
);

   localparam int SB = lseg_pkg::SAMPLE_BITS;
   localparam int CB = COEF_BITS;
   localparam int WW = lseg_pkg::WET_BITS;
   localparam int CSR_W = (SB > CB + 1) ? SB : CB + 1;
   localparam int KEEP_W = CB + 1;
   localparam int LF = CB - 2;                      // level fraction bits
   // multiplicand: sample/level differences; multiplier: coefficients (reversed in the attack product)
   localparam int A_W = (SB + 2 > CB + 2) ? SB + 2 : CB + 2;
   localparam int B_W0 = (SB + 2 > CB + 2) ? SB + 2 : CB + 2;
   localparam int B_W = (B_W0 > WW + 1) ? B_W0 : WW + 1;
   localparam int P_W = A_W + 1 + B_W;
   localparam logic [CB-1:0] LEVEL_ONE = CB'(1) << LF;
   localparam logic [CB-1:0] LEVEL_TWO = CB'(1) << (LF + 1);
   localparam logic [KEEP_W-1:0] KEEP_ONE = KEEP_W'(1) << CB;
   localparam logic [WW-1:0] WET_ONE = WW'(1) << lseg_pkg::WET_FRAC;
   localparam logic signed [P_W-1:0] SMAX = P_W'((64'sd1 <<< (SB - 1)) - 1);
   localparam logic signed [P_W-1:0] SMIN = -P_W'(64'sd1 <<< (SB - 1));
   localparam logic [KEEP_W-1:0] TKEEP_RST =
      KEEP_W'((lseg_pkg::TREBLE_KEEP_RST << CB) >> lseg_pkg::RST_COEF_BITS);
   localparam logic [KEEP_W-1:0] BKEEP_RST =
      KEEP_W'((lseg_pkg::BASS_KEEP_RST << CB) >> lseg_pkg::RST_COEF_BITS);
   localparam logic [CB-1:0] ATK_RST =
      CB'((lseg_pkg::ATTACK_BASE_RST << CB) >> lseg_pkg::RST_COEF_BITS);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SETUP = 4'b0010,
      ST_MULT  = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   // product sequence of one frame
   typedef enum logic [3:0] {
      OP_ATK, OP_TRE, OP_BAS, OP_LP0, OP_HP0, OP_MIX0, OP_LP1, OP_HP1, OP_MIX1
   } op_type;

   // config registers
   logic [SB-1:0]     thr_ff;
   logic [KEEP_W-1:0] tkeep_ff;
   logic [KEEP_W-1:0] bkeep_ff;
   logic [CB-1:0]     atk_base_ff;
   logic [WW-1:0]     wet_ff;

   // frame state
   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic signed [SB-1:0]   x_ff [2];
   logic [SB-1:0]          mag_ff;
   logic [CB-1:0]          treble_ff, treble_in;
   logic [CB-1:0]          bass_ff, bass_in;
   logic signed [SB-1:0]   lp_ff [4];
   logic signed [SB-1:0]   hp_ff [4];
   logic signed [SB-1:0]   lp_in [4];
   logic signed [SB-1:0]   hp_in [4];
   logic                   bank_ff, bank_in;
   logic signed [SB-1:0]   out_ff [2];
   logic signed [SB-1:0]   out_in [2];
   logic                   rsp_valid_ff;
   lseg_pkg::rsp_type      rsp_data_ff;

   // multiplier hookup
   logic                   mul_start;
   logic                   mul_done;
   logic signed [A_W-1:0]  mul_a;
   logic signed [B_W-1:0]  mul_b;
   logic signed [P_W-1:0]  mul_p;

   logic                   ch;
   logic [1:0]             idx;
   logic signed [P_W-1:0]  xe, lpe, hpe, tre, bae, gated;
   logic signed [P_W-1:0]  r_cb, r_lf, r_sb, r_wet;
   logic signed [P_W-1:0]  atk, t_open, b_open, lvl, v;
   logic [SB-1:0]          mag0, mag1, mag_max;
   logic                   req_acc;
   logic                   rsp_free;

   // round to nearest, ties up (arithmetic shift floors)
   function automatic logic signed [P_W-1:0] rnd(input logic signed [P_W-1:0] p,
                                                 input int s);
      logic signed [P_W-1:0] half;
      half = $signed(P_W'(1)) <<< (s - 1);
      rnd = (p + half) >>> s;
   endfunction

   function automatic logic signed [P_W-1:0] sat(input logic signed [P_W-1:0] p);
      if (p > SMAX) begin
         sat = SMAX;
      end else if (p < SMIN) begin
         sat = SMIN;
      end else begin
         sat = p;
      end
   endfunction

   assign req_acc = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // config writes, keep and wet saturate to one
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
         tkeep_ff <= TKEEP_RST;
         bkeep_ff <= BKEEP_RST;
         atk_base_ff <= ATK_RST;
         wet_ff <= WET_ONE;
      end else if (csr_we) begin
         unique case (csr_index)
            lseg_pkg::REG_THRESHOLD: thr_ff <= csr_data[SB-1:0];
            lseg_pkg::REG_TREBLE_KEEP:
               tkeep_ff <= (csr_data[KEEP_W-1:0] > KEEP_ONE) ? KEEP_ONE
                                                              : csr_data[KEEP_W-1:0];
            lseg_pkg::REG_BASS_KEEP:
               bkeep_ff <= (csr_data[KEEP_W-1:0] > KEEP_ONE) ? KEEP_ONE
                                                              : csr_data[KEEP_W-1:0];
            lseg_pkg::REG_ATTACK_BASE: atk_base_ff <= csr_data[CB-1:0];
            lseg_pkg::REG_WET_MIX:
               wet_ff <= (csr_data[WW-1:0] > WET_ONE) ? WET_ONE : csr_data[WW-1:0];
            default: ;
         endcase
      end
   end

   // channel of the current op and its slot in the filter banks (bank 1 = A)
   assign ch = (op_ff == OP_LP1) || (op_ff == OP_HP1) || (op_ff == OP_MIX1);
   assign idx = {bank_ff, ch};
   assign xe = P_W'(x_ff[ch]);
   assign lpe = P_W'(lp_ff[idx]);
   assign hpe = P_W'(hp_ff[idx]);
   assign tre = $signed(P_W'(treble_ff));
   assign bae = $signed(P_W'(bass_ff));
   assign gated = (treble_ff > bass_ff) ? (lpe - hpe) : '0;

   // operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op_ff) inside
         OP_ATK: begin
            mul_a = $signed(A_W'(atk_base_ff));
            mul_b = $signed(B_W'(mag_max));
         end
         OP_TRE: begin
            mul_a = A_W'(tre - bae);
            mul_b = $signed(B_W'(tkeep_ff));
         end
         OP_BAS: begin
            mul_a = A_W'(bae - tre);
            mul_b = $signed(B_W'(bkeep_ff));
         end
         OP_LP0, OP_LP1: begin
            mul_a = A_W'(xe - lpe);
            mul_b = $signed(B_W'(treble_ff));
         end
         OP_HP0, OP_HP1: begin
            mul_a = A_W'(xe - hpe);
            mul_b = $signed(B_W'(bass_ff));
         end
         default: begin
            mul_a = A_W'(gated - xe);
            mul_b = $signed(B_W'(wet_ff));
         end
      endcase
   end

   assign mul_start = (state_ff == ST_SETUP);

   lseg_smul #(
      .A_W(A_W),
      .B_W(B_W)
   ) u_smul (
      .clock(clock),
      .reset(reset),
      .start(mul_start),
      .a(mul_a),
      .b(mul_b),
      .done(mul_done),
      .prod(mul_p)
   );

   assign r_cb = rnd(mul_p, CB);
   assign r_lf = rnd(mul_p, LF);
   assign r_sb = rnd(mul_p, SB);
   assign r_wet = rnd(mul_p, lseg_pkg::WET_FRAC);

   // open gate: attack step never goes negative since it loses at most half
   assign atk = $signed(P_W'(atk_base_ff)) - r_sb;
   assign t_open = (tre + atk > $signed(P_W'(LEVEL_TWO))) ? $signed(P_W'(LEVEL_TWO))
                                                          : tre + atk;
   assign b_open = (bae - (atk <<< 1) < 0) ? '0 : bae - (atk <<< 1);

   assign mag0 = x_ff[0][SB-1] ? SB'(-x_ff[0]) : SB'(x_ff[0]);
   assign mag1 = x_ff[1][SB-1] ? SB'(-x_ff[1]) : SB'(x_ff[1]);
   // louder channel, fed straight to the first product from the input registers
   assign mag_max = (mag0 > mag1) ? mag0 : mag1;

   // sequencer and write-back of each product
   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      treble_in = treble_ff;
      bass_in = bass_ff;
      bank_in = bank_ff;
      lp_in = lp_ff;
      hp_in = hp_ff;
      out_in = out_ff;
      lvl = '0;
      v = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_SETUP;
               op_in = OP_ATK;
            end
         end
         ST_SETUP: state_in = ST_MULT;
         ST_MULT: begin
            if (mul_done) begin
               state_in = ST_SETUP;
               case (op_ff) inside
                  OP_ATK: begin
                     if (mag_ff > thr_ff) begin
                        treble_in = CB'(t_open);
                        lvl = (b_open > $signed(P_W'(LEVEL_ONE))) ?
                              $signed(P_W'(LEVEL_ONE)) : b_open;
                        bass_in = CB'(lvl);
                        for (int i = 0; i < 4; i++) begin
                           lp_in[i] = x_ff[i % 2];
                           hp_in[i] = '0;
                        end
                        op_in = OP_LP0;
                     end else begin
                        op_in = OP_TRE;
                     end
                  end
                  OP_TRE: begin
                     treble_in = CB'(bae + r_cb);
                     op_in = OP_BAS;
                  end
                  OP_BAS: begin
                     lvl = tre + r_cb;
                     if (lvl > $signed(P_W'(LEVEL_ONE))) begin
                        lvl = $signed(P_W'(LEVEL_ONE));
                     end
                     bass_in = CB'(lvl);
                     op_in = OP_LP0;
                  end
                  OP_LP0, OP_LP1: begin
                     lp_in[idx] = (treble_ff >= LEVEL_ONE) ? x_ff[ch] : SB'(lpe + r_lf);
                     op_in = ch ? OP_HP1 : OP_HP0;
                  end
                  OP_HP0, OP_HP1: begin
                     hp_in[idx] = (bass_ff != '0) ? SB'(hpe + r_lf) : '0;
                     op_in = ch ? OP_MIX1 : OP_MIX0;
                  end
                  default: begin
                     v = sat(xe + r_wet);
                     out_in[ch] = SB'(v);
                     if (ch) begin
                        state_in = ST_OUT;
                        bank_in = !bank_ff;
                     end else begin
                        op_in = OP_LP1;
                     end
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff <= OP_ATK;
         treble_ff <= LEVEL_ONE;
         bass_ff <= '0;
         bank_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            lp_ff[i] <= '0;
            hp_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         treble_ff <= treble_in;
         bass_ff <= bass_in;
         bank_ff <= bank_in;
         lp_ff <= lp_in;
         hp_ff <= hp_in;
         if (state_ff == ST_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         x_ff[0] <= req_data.sample_left;
         x_ff[1] <= req_data.sample_right;
      end
      if (state_ff == ST_SETUP && op_ff == OP_ATK) begin
         mag_ff <= mag_max;
      end
      out_ff <= out_in;
      if (state_ff == ST_OUT && rsp_free) begin
         rsp_data_ff.out_left <= out_ff[0];
         rsp_data_ff.out_right <= out_ff[1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // level bounds, multiplier handshake and frame start
   a_bass_bound: assert property (@(posedge clock) disable iff (reset)
      bass_ff <= LEVEL_ONE) else $error("bass level above one");
   a_treble_bound: assert property (@(posedge clock) disable iff (reset)
      treble_ff <= LEVEL_TWO) else $error("treble level above two");
   a_done_in_mult: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_MULT) else $error("product finished outside multiply");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == ST_SETUP && op_ff == OP_ATK))
      else $error("accepted frame did not start");

endmodule

>>> sv/lseg_smul.sv
module lseg_smul #(
   parameter int A_W = 26,
   parameter int B_W = 26
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [A_W-1:0]   a,
   input  logic signed [B_W-1:0]   b,
   output logic                    done,
   output logic signed [A_W+B_W:0] prod
);

   localparam int CNT_W = $clog2(B_W + 1);

   logic signed [A_W-1:0] a_ff;
   logic signed [A_W:0]   hi_ff;
   logic [B_W-1:0]        lo_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic                  last;
   logic signed [A_W+1:0] addend;
   logic signed [A_W+1:0] sum;

   // multiplier bits retire LSB first; the sign bit carries negative weight
   assign last = (cnt_ff == CNT_W'(B_W - 1));

   always_comb begin
      if (!lo_ff[0]) begin
         addend = '0;
      end else if (last) begin
         addend = -((A_W+2)'(a_ff));
      end else begin
         addend = (A_W+2)'(a_ff);
      end
      sum = (A_W+2)'(hi_ff) + addend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
         hi_ff <= '0;
         lo_ff <= b;
      end else if (busy_ff) begin
         hi_ff <= sum[A_W+1:1];
         lo_ff <= {sum[0], lo_ff[B_W-1:1]};
      end
   end

   assign done = done_ff;
   assign prod = {hi_ff, lo_ff};

endmodule

>>> sim/linked_stereo_envelope_gate_top_tb.sv
`timescale 1ns / 100ps

module linked_stereo_envelope_gate_top_tb;

   localparam int  SBITS = lseg_pkg::SAMPLE_BITS;
   localparam int  IBITS = lseg_pkg::CSR_INDEX_BITS;
   localparam int  CBITS = lseg_pkg::COEF_BITS_DEF;
   localparam int  LFRAC = CBITS - 2;
   localparam longint LVL_ONE = longint'(1) << LFRAC;
   localparam longint KEEP_ONE = longint'(1) << CBITS;
   localparam longint WET_ONE = 65536;
   localparam longint S_MAX = (longint'(1) << (SBITS - 1)) - 1;
   localparam longint S_MIN = -(longint'(1) << (SBITS - 1));
   // allow a margin for draining a frame
   localparam int  DRAIN_CYCLES = 400;
   localparam int  CYCLE_LIMIT = 1_500_000;
   localparam int  CSR_W = (SBITS > CBITS + 1) ? SBITS : CBITS + 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   lseg_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   lseg_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [IBITS-1:0] csr_index = lseg_pkg::REG_THRESHOLD;
   logic [CSR_W-1:0] csr_data = '0;

   // ------------------------------------------------------------------
   // Expected-frame model state: gate registers plus filter banks
   // ------------------------------------------------------------------
   longint gate_threshold, keep_treble, keep_bass, attack_step_base, wet_frac;
   longint level_treble, level_bass;
   longint lp_bank [2][2];   // [bank: 1 = A, 0 = B][channel]
   longint hp_bank [2][2];
   int     bank_sel;

   lseg_pkg::rsp_type expected_frames[$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   bit      idle_on = 1'b1;    // random idling enabled on both sides
   int      hold_left = 0;     // receiver hold-off cycles remaining

   always #2 clock = ~clock;

   linked_stereo_envelope_gate_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // round to nearest, ties upward; arithmetic shift gives the floor
   function automatic longint round_shift(longint p, int s);
      return (p + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clip_sample(longint v);
      if (v > S_MAX) return S_MAX;
      if (v < S_MIN) return S_MIN;
      return v;
   endfunction

   task automatic gate_model_reset();
      gate_threshold = 0;
      keep_treble = lseg_pkg::TREBLE_KEEP_RST;
      keep_bass = lseg_pkg::BASS_KEEP_RST;
      attack_step_base = lseg_pkg::ATTACK_BASE_RST;
      wet_frac = WET_ONE;
      level_treble = LVL_ONE;
      level_bass = 0;
      lp_bank = '{'{0, 0}, '{0, 0}};
      hp_bank = '{'{0, 0}, '{0, 0}};
      bank_sel = 0;
   endtask

   task automatic gate_model_write(logic [IBITS-1:0] idx, longint val);
      case (idx)
         lseg_pkg::REG_THRESHOLD: gate_threshold = val & ((longint'(1) << SBITS) - 1);
         lseg_pkg::REG_TREBLE_KEEP: begin
            keep_treble = val & ((longint'(1) << (CBITS + 1)) - 1);
            if (keep_treble > KEEP_ONE) keep_treble = KEEP_ONE;
         end
         lseg_pkg::REG_BASS_KEEP: begin
            keep_bass = val & ((longint'(1) << (CBITS + 1)) - 1);
            if (keep_bass > KEEP_ONE) keep_bass = KEEP_ONE;
         end
         lseg_pkg::REG_ATTACK_BASE: attack_step_base = val & ((longint'(1) << CBITS) - 1);
         lseg_pkg::REG_WET_MIX: begin
            wet_frac = val & 64'h1FFFF;
            if (wet_frac > WET_ONE) wet_frac = WET_ONE;
         end
         default: ;
      endcase
   endtask

   // advance the model by one frame and queue the expected output frame
   task automatic gate_model_frame(lseg_pkg::req_type f);
      longint x [2];
      longint mag, atk, gated, y;
      lseg_pkg::rsp_type r;
      x[0] = longint'($signed(f.sample_left));
      x[1] = longint'($signed(f.sample_right));
      mag = (x[0] < 0 ? -x[0] : x[0]);
      if ((x[1] < 0 ? -x[1] : x[1]) >= mag) mag = (x[1] < 0 ? -x[1] : x[1]);
      atk = attack_step_base - round_shift(attack_step_base * mag, SBITS);
      if (atk < 0) atk = 0;

      if (mag > gate_threshold) begin
         // gate opens: levels jump, every lowpass snaps to the input, every highpass clears
         level_treble += atk;
         if (level_treble > 2 * LVL_ONE) level_treble = 2 * LVL_ONE;
         level_bass -= 2 * atk;
         if (level_bass < 0) level_bass = 0;
         for (int c = 0; c < 2; c++) begin
            lp_bank[0][c] = x[c];
            lp_bank[1][c] = x[c];
            hp_bank[0][c] = 0;
            hp_bank[1][c] = 0;
         end
      end else begin
         level_treble = level_bass +
            round_shift((level_treble - level_bass) * keep_treble, CBITS);
         level_bass = level_treble +
            round_shift((level_bass - level_treble) * keep_bass, CBITS);
      end
      if (level_bass > LVL_ONE) level_bass = LVL_ONE;

      for (int c = 0; c < 2; c++) begin
         if (level_treble >= LVL_ONE)
            lp_bank[bank_sel][c] = x[c];
         else
            lp_bank[bank_sel][c] += round_shift((x[c] - lp_bank[bank_sel][c]) *
                                                level_treble, LFRAC);
         if (level_bass > 0)
            hp_bank[bank_sel][c] += round_shift((x[c] - hp_bank[bank_sel][c]) *
                                                level_bass, LFRAC);
         else
            hp_bank[bank_sel][c] = 0;
         // closed gate when treble is not above bass: dry part only
         gated = (level_treble > level_bass) ?
                 (lp_bank[bank_sel][c] - hp_bank[bank_sel][c]) : 0;
         y = clip_sample(x[c] + round_shift((gated - x[c]) * wet_frac, 16));
         if (c == 0) r.out_left = y[SBITS-1:0];
         else        r.out_right = y[SBITS-1:0];
      end
      bank_sel ^= 1;
      expected_frames.push_back(r);
   endtask

   // ------------------------------------------------------------------
   // Stimulus side
   // ------------------------------------------------------------------
   // Offer one frame; valid stays high afterwards so back-to-back frames
   // keep it asserted. The model advances on the accepting edge.
   task automatic send_frame(logic signed [SBITS-1:0] l,
                             logic signed [SBITS-1:0] r);
      lseg_pkg::req_type f;
      f.sample_left = l;
      f.sample_right = r;
      while (idle_on && $urandom_range(99) < 7) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = f;
      do @(posedge clock); while (req_stall);
      gate_model_frame(f);
      @(negedge clock);
   endtask

   // config writes only with the block idle: drained, then a latency pause
   task automatic write_reg(logic [IBITS-1:0] idx, longint val);
      req_valid = 1'b0;
      wait (expected_frames.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_data = val[CSR_W-1:0];
      @(negedge clock);
      csr_we = 1'b0;
      gate_model_write(idx, val);
   endtask

   function automatic logic signed [SBITS-1:0] pick_sample();
      int sel;
      sel = $urandom_range(99);
      if (sel < 45) return SBITS'($urandom());
      if (sel < 80) return SBITS'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
      if (sel < 90) return S_MAX[SBITS-1:0];
      return S_MIN[SBITS-1:0];
   endfunction

   task automatic test_directed_extremes();
      send_frame(0, 0);
      send_frame(S_MAX[SBITS-1:0], S_MIN[SBITS-1:0]);
      send_frame(S_MIN[SBITS-1:0], S_MAX[SBITS-1:0]);
      send_frame(-24'sd5000, 24'sd5000);          // equal magnitudes
      send_frame(24'sd1, -24'sd1);
      send_frame(24'h555555, 24'hAAAAAA);
      send_frame(24'hAAAAAA, 24'h555555);
   endtask

   task automatic test_closed_gate_decay();
      // threshold above full scale never opens; zero treble keep collapses
      // treble onto bass so the output becomes the dry part alone
      write_reg(lseg_pkg::REG_THRESHOLD, 24'hFFFFFF);
      write_reg(lseg_pkg::REG_WET_MIX, 32768);
      repeat (4) send_frame(pick_sample(), pick_sample());
      write_reg(lseg_pkg::REG_TREBLE_KEEP, 0);
      write_reg(lseg_pkg::REG_BASS_KEEP, 0);
      repeat (4) send_frame(pick_sample(), pick_sample());
   endtask

   task automatic test_saturating_registers();
      // keep and wet values above one clip to one
      write_reg(lseg_pkg::REG_TREBLE_KEEP, (longint'(1) << (CBITS + 1)) - 1);
      write_reg(lseg_pkg::REG_BASS_KEEP, KEEP_ONE + 7);
      write_reg(lseg_pkg::REG_WET_MIX, 17'h1FFFF);
      write_reg(lseg_pkg::REG_ATTACK_BASE, (longint'(1) << CBITS) - 1);
      write_reg(lseg_pkg::REG_THRESHOLD, 1000);
      send_frame(S_MIN[SBITS-1:0], 24'sd3);
      send_frame(24'sd10, -24'sd20);
      send_frame(S_MAX[SBITS-1:0], S_MAX[SBITS-1:0]);
      write_reg(lseg_pkg::REG_WET_MIX, 0);
      write_reg(lseg_pkg::REG_ATTACK_BASE, 0);
      send_frame(24'sd123456, -24'sd654321);
      send_frame(24'sd2, 24'sd1);
   endtask

   // random configuration phases, each followed by a burst of frames
   task automatic test_random_frames(int phases, int per_phase);
      for (int p = 0; p < phases; p++) begin
         write_reg(lseg_pkg::REG_THRESHOLD,
                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 1 << 24)
                   : $urandom_range(0, 1 << 18));
         write_reg(lseg_pkg::REG_TREBLE_KEEP,
                   $urandom_range(0, 7) == 0 ? $urandom_range(0, 1 << 25)
                   : KEEP_ONE - $urandom_range(0, 1 << 14));
         write_reg(lseg_pkg::REG_BASS_KEEP,
                   $urandom_range(0, 7) == 0 ? $urandom_range(0, 1 << 25)
                   : KEEP_ONE - $urandom_range(0, 1 << 14));
         write_reg(lseg_pkg::REG_ATTACK_BASE,
                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 1 << 24)
                   : $urandom_range(0, 1 << 18));
         write_reg(lseg_pkg::REG_WET_MIX, $urandom_range(0, 1 << 17));
         idle_on = (p != 1);   // one phase with no idling at all
         for (int i = 0; i < per_phase; i++)
            send_frame(pick_sample(), pick_sample());
         idle_on = 1'b1;
      end
   endtask

   task automatic test_backpressure();
      // long receiver hold-off while frames keep coming: input must stall
      hold_left = 3000;
      repeat (20) send_frame(pick_sample(), pick_sample());
   endtask

   // receiver stall generation
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = idle_on && ($urandom_range(99) < 7);
      end
   end

   // output checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transaction: %h", rsp_data);
         end else begin
            lseg_pkg::rsp_type e;
            e = expected_frames.pop_front();
            if (rsp_data.out_left !== e.out_left || rsp_data.out_right !== e.out_right) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: left exp %h got %h, right exp %h got %h",
                           e.out_left, rsp_data.out_left, e.out_right, rsp_data.out_right);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("linked_stereo_envelope_gate_top_tb NOT OK");
         $finish;
      end
   end

   initial begin
      gate_model_reset();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_extremes();
      test_closed_gate_decay();
      test_saturating_registers();
      test_backpressure();
      test_random_frames(6, 145);

      req_valid = 1'b0;
      wait (expected_frames.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_frames.size() == 0)
         $display("linked_stereo_envelope_gate_top_tb OK");
      else
         $display("linked_stereo_envelope_gate_top_tb NOT OK");
      $finish;
   end

endmodule
